// ===== hdl/psh_pkg.sv =====
// Package for the packet segmenter with header insertion.
// Holds shared widths, header constants, register codes and the front-to-back command.
// No dependencies.
package psh_pkg;

	localparam int HEADER_BYTES     = 20;
	localparam int HDR_IDX_BITS     = $clog2(HEADER_BYTES);
	localparam int MAX_PAYLOAD_BITS = 14;
	localparam int DATA_ID_BITS     = 16;
	localparam int TICK_BITS        = 64;
	localparam int INDEX_BITS       = 32;
	localparam int CFG_INDEX_BITS   = 2;
	localparam int CFG_DATA_BITS    = 16;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MAX_PAYLOAD_BITS-1:0] MAX_PAYLOAD_RESET = 14'd1420;
	localparam logic [DATA_ID_BITS-1:0]     DATA_ID_RESET     = 16'h7777;

	localparam logic [7:0] LB_MAGIC_0 = 8'd123;
	localparam logic [7:0] LB_VERSION = 8'd1;
	localparam logic [7:0] LB_CHAR_B  = 8'h42;
	localparam logic [7:0] LB_CHAR_L  = 8'h4c;
	localparam logic [7:0] RE_VERSION = 8'h01;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MAX_PAYLOAD = 2'd0,
		REG_DATA_ID     = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]              data_byte;
		logic                    need_hdr;
		logic [TICK_BITS-1:0]    tick;
		logic [DATA_ID_BITS-1:0] data_id;
		logic                    last_pkt;
		logic                    first_pkt;
		logic [INDEX_BITS-1:0]   pkt_index;
		logic                    pkt_end;
		logic                    buf_end;
	} cmd_t;

endpackage

// ===== hdl/psh_in_if.sv =====
// Input byte channel: valid/ready handshake with byte, buffer length and tick.
// Depends on psh_pkg.
interface psh_in_if #(parameter int LENGTH_BITS = 20);
	import psh_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [7:0]             data_byte;
	logic [LENGTH_BITS-1:0] buffer_length;
	logic [TICK_BITS-1:0]   event_tick;

	modport source (output valid, output data_byte, output buffer_length, output event_tick,
		input ready);
	modport sink (input valid, input data_byte, input buffer_length, input event_tick,
		output ready);
endinterface

// ===== hdl/psh_out_if.sv =====
// Output word channel: valid/ready handshake with packet byte and framing flags.
// No dependencies.
interface psh_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_header;
	logic       packet_start;
	logic       packet_end;
	logic       buffer_end;
	logic       last_of_run;

	modport source (output valid, output out_byte, output is_header, output packet_start,
		output packet_end, output buffer_end, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input is_header, input packet_start,
		input packet_end, input buffer_end, input last_of_run, output ready);
endinterface

// ===== hdl/psh_front.sv =====
// Front end: configuration registers, buffer and packet accounting, command build.
// Depends on psh_pkg.
module psh_front #(
	parameter int LENGTH_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [psh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [psh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_data_byte,
	input  logic [LENGTH_BITS-1:0]        in_buffer_length,
	input  logic [psh_pkg::TICK_BITS-1:0] in_event_tick,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output psh_pkg::cmd_t                 cmd
);
	import psh_pkg::*;

	localparam int CW = (LENGTH_BITS > MAX_PAYLOAD_BITS) ? LENGTH_BITS : MAX_PAYLOAD_BITS;

	logic [MAX_PAYLOAD_BITS-1:0] max_payload_q;
	logic [DATA_ID_BITS-1:0]     data_id_q;
	logic [LENGTH_BITS-1:0]      bytes_rem_q;
	logic [MAX_PAYLOAD_BITS-1:0] pkt_left_q;
	logic [INDEX_BITS-1:0]       pkt_index_q;
	logic [TICK_BITS-1:0]        tick_q;
	logic                        first_q;

	logic                        open_buf;
	logic                        accept;
	logic [LENGTH_BITS-1:0]      rem_cur;
	logic [MAX_PAYLOAD_BITS-1:0] left_cur;
	logic [INDEX_BITS-1:0]       index_cur;
	logic [TICK_BITS-1:0]        tick_cur;
	logic                        first_cur;
	logic                        need_hdr;
	logic [MAX_PAYLOAD_BITS-1:0] lim;
	logic [MAX_PAYLOAD_BITS-1:0] n;
	logic                        last_pkt;
	logic [MAX_PAYLOAD_BITS-1:0] left_new;
	logic [LENGTH_BITS-1:0]      rem_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
			data_id_q     <= DATA_ID_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data[MAX_PAYLOAD_BITS-1:0];
				REG_DATA_ID:     data_id_q     <= cfg_data[DATA_ID_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign open_buf  = (bytes_rem_q != '0);
	assign rem_cur   = open_buf ? bytes_rem_q :
		((in_buffer_length == '0) ? LENGTH_BITS'(1) : in_buffer_length);
	assign left_cur  = open_buf ? pkt_left_q : '0;
	assign index_cur = open_buf ? pkt_index_q : '0;
	assign tick_cur  = open_buf ? tick_q : in_event_tick;
	assign first_cur = open_buf ? first_q : 1'b1;
	assign need_hdr  = (left_cur == '0);
	assign lim       = (max_payload_q == '0) ? MAX_PAYLOAD_BITS'(1) : max_payload_q;
	assign n         = (CW'(rem_cur) > CW'(lim)) ? lim : MAX_PAYLOAD_BITS'(rem_cur);
	assign last_pkt  = (CW'(n) == CW'(rem_cur));
	assign left_new  = (need_hdr ? n : left_cur) - MAX_PAYLOAD_BITS'(1);
	assign rem_new   = rem_cur - LENGTH_BITS'(1);

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;

	always_comb begin
		cmd.data_byte = in_data_byte;
		cmd.need_hdr  = need_hdr;
		cmd.tick      = tick_cur;
		cmd.data_id   = data_id_q;
		cmd.last_pkt  = last_pkt;
		cmd.first_pkt = first_cur;
		cmd.pkt_index = index_cur;
		cmd.pkt_end   = (left_new == '0);
		cmd.buf_end   = (rem_new == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_rem_q <= '0;
			pkt_left_q  <= '0;
			pkt_index_q <= '0;
			tick_q      <= '0;
			first_q     <= 1'b1;
		end else if (accept) begin
			bytes_rem_q <= rem_new;
			pkt_left_q  <= left_new;
			pkt_index_q <= need_hdr ? index_cur + INDEX_BITS'(1) : index_cur;
			tick_q      <= tick_cur;
			first_q     <= need_hdr ? 1'b0 : first_cur;
		end
	end
endmodule

// ===== hdl/psh_queue.sv =====
// Short command queue between front and back ends.
// Depends on psh_pkg.
module psh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  psh_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output psh_pkg::cmd_t pop_data
);
	import psh_pkg::*;

	cmd_t                      entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      push;
	logic                      pop;

	assign push_ready = (count_q != QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_BITS'(1);
			end
		end
	end
endmodule

// ===== hdl/psh_back.sv =====
// Back end: header sequencer and output register.
// Depends on psh_pkg.
module psh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  psh_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_is_header,
	output logic          out_packet_start,
	output logic          out_packet_end,
	output logic          out_buffer_end,
	output logic          out_last_of_run
);
	import psh_pkg::*;

	logic [HDR_IDX_BITS-1:0] hdr_cnt_q;
	logic                    hdr_done_q;
	logic                    out_valid_q;
	logic [7:0]              byte_q;
	logic                    is_header_q;
	logic                    start_q;
	logic                    pend_q;
	logic                    bend_q;
	logic                    last_q;

	logic [7:0]              hb [HEADER_BYTES];
	logic                    in_hdr;
	logic                    load;

	always_comb begin
		hb[0]  = LB_MAGIC_0;
		hb[1]  = LB_VERSION;
		hb[2]  = LB_CHAR_B;
		hb[3]  = LB_CHAR_L;
		for (int i = 0; i < 8; i++) begin
			hb[4 + i] = cmd.tick[(7 - i) * 8 +: 8];
		end
		hb[12] = cmd.data_id[15:8];
		hb[13] = cmd.data_id[7:0];
		hb[14] = {cmd.last_pkt, cmd.first_pkt, 6'b0};
		hb[15] = RE_VERSION;
		hb[16] = cmd.pkt_index[31:24];
		hb[17] = cmd.pkt_index[23:16];
		hb[18] = cmd.pkt_index[15:8];
		hb[19] = cmd.pkt_index[7:0];
	end

	assign in_hdr    = cmd.need_hdr && !hdr_done_q;
	assign load      = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_ready = load && !in_hdr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			hdr_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (in_hdr) begin
					if (hdr_cnt_q == HDR_IDX_BITS'(HEADER_BYTES - 1)) begin
						hdr_cnt_q  <= '0;
						hdr_done_q <= 1'b1;
					end else begin
						hdr_cnt_q <= hdr_cnt_q + HDR_IDX_BITS'(1);
					end
				end else begin
					hdr_done_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q      <= in_hdr ? hb[hdr_cnt_q] : cmd.data_byte;
			is_header_q <= in_hdr;
			start_q     <= in_hdr && (hdr_cnt_q == '0);
			pend_q      <= !in_hdr && cmd.pkt_end;
			bend_q      <= !in_hdr && cmd.buf_end;
			last_q      <= !in_hdr;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_byte         = byte_q;
	assign out_is_header    = is_header_q;
	assign out_packet_start = start_q;
	assign out_packet_end   = pend_q;
	assign out_buffer_end   = bend_q;
	assign out_last_of_run  = last_q;
endmodule

// ===== hdl/packet_segmenter_header_insert_top.sv =====
// Top level of the packet segmenter with header insertion.
// Depends on psh_pkg, psh_in_if, psh_out_if, psh_front, psh_queue, psh_back.
//
//   channel   dir  contents                                    handshake
//   in_ch     in   data_byte, buffer_length, event_tick        valid/ready
//   out_ch    out  out_byte, is_header, packet_start, ...      valid/ready
//   cfg       in   cfg_wr_en, cfg_index, cfg_data              write strobe
//
// One output word per cycle while the output is not stalled; the first byte of a
// packet comes after 20 header words from the back-end sequencer.
// Input accepts one byte per cycle while the two-entry command queue has room.
// Either side may stall independently; the output register holds until taken.
// Reset clears all accounting; registers return to their default values.
module packet_segmenter_header_insert_top #(
	parameter int LENGTH_BITS = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [psh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [psh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	psh_in_if.sink                             in_ch,
	psh_out_if.source                          out_ch
);
	import psh_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	psh_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_ch.valid),
		.in_ready         (in_ch.ready),
		.in_data_byte     (in_ch.data_byte),
		.in_buffer_length (in_ch.buffer_length),
		.in_event_tick    (in_ch.event_tick),
		.cmd_valid        (cmd_valid),
		.cmd_ready        (cmd_ready),
		.cmd              (cmd)
	);

	psh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_valid),
		.push_ready (cmd_ready),
		.push_data  (cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	psh_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (q_valid),
		.cmd_ready        (q_ready),
		.cmd              (q_cmd),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_byte         (out_ch.out_byte),
		.out_is_header    (out_ch.is_header),
		.out_packet_start (out_ch.packet_start),
		.out_packet_end   (out_ch.packet_end),
		.out_buffer_end   (out_ch.buffer_end),
		.out_last_of_run  (out_ch.last_of_run)
	);
endmodule
